// ----- rtl/ets_pkg.sv -----
// ----------------------------------------------------------------------------
// ets_pkg
// Shared types, constants and the month length table for the epoch seconds
// to calendar converter.
// ----------------------------------------------------------------------------
package ets_pkg;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;

  localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
  localparam logic [6:0]  EPOCH_MOD100  = 7'd70;
  localparam logic [8:0]  EPOCH_MOD400  = 9'd370;
  localparam logic [6:0]  LAST_MOD100   = 7'd99;
  localparam logic [8:0]  LAST_MOD400   = 9'd399;

  localparam logic [8:0]  DAYS_COMMON   = 9'd365;
  localparam logic [8:0]  DAYS_LEAP     = 9'd366;

  localparam logic [3:0]  MONTH_JAN     = 4'd1;
  localparam logic [3:0]  MONTH_FEB     = 4'd2;
  localparam logic [3:0]  MONTH_DEC     = 4'd12;

  // Rounded-up reciprocals for quotient by multiply and shift: 675 (86400 >> 7)
  // scaled by 2^35, 225 (3600 >> 4) by 2^21, 15 (60 >> 2) by 2^14.
  localparam logic [25:0] RECIP_DAY     = 26'd50903317;
  localparam logic [25:0] RECIP_HOUR    = 26'd9321;
  localparam logic [25:0] RECIP_MIN     = 26'd1093;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DAY,
    S_HOUR_INIT,
    S_HOUR,
    S_MIN_INIT,
    S_MIN,
    S_TOD_DONE,
    S_YEAR,
    S_MONTH,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_step;
    div_sel_t dsel;
    logic     hour_init;
    logic     min_init;
    logic     tod_done;
    logic     year_step;
    logic     month_step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } stat_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/ets_if.sv -----
// ----------------------------------------------------------------------------
// ets_if
// Valid/ready channels carrying epoch seconds in and calendar fields out.
// ----------------------------------------------------------------------------
interface ets_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] seconds_since_epoch;

  modport source (output valid, output seconds_since_epoch, input ready);
  modport sink   (input valid, input seconds_since_epoch, output ready);
endinterface

interface ets_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input hour, input minute, input second, output ready);
endinterface

// ----- rtl/epoch_seconds_to_calendar.sv -----
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into the
// Gregorian year, month, day of month, hour, minute and second.
// ----------------------------------------------------------------------------
// One conversion is in flight at a time. After the input transfer come six
// steps for the day quotient, the seconds of day, the hour, the seconds left
// after the hours, the minute and the second, each a multiply by a constant
// reciprocal or a subtract, then the year walk from 1970, one whole year per
// step, and the month walk, one whole month per step, each closed by a final
// check, and last the load of the result, which waits while the previous
// result is still untaken. The block then returns to idle before the next
// input is taken. A finished result sits in an output register, so the next
// input is taken while the previous result still waits for transfer.
module epoch_seconds_to_calendar (
  input  logic            clk,
  input  logic            rst,
  ets_in_if.sink          in_ch,
  ets_out_if.source       out_ch
);

  ets_pkg::cmd_t  cmd;
  ets_pkg::stat_t stat;

  ets_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  ets_datapath u_datapath (
    .clk                 (clk),
    .cmd                 (cmd),
    .seconds_since_epoch (in_ch.seconds_since_epoch),
    .stat                (stat),
    .year                (out_ch.year),
    .month               (out_ch.month),
    .day_of_month        (out_ch.day_of_month),
    .hour                (out_ch.hour),
    .minute              (out_ch.minute),
    .second              (out_ch.second)
  );

endmodule

// ----- rtl/ets_datapath.sv -----
// ----------------------------------------------------------------------------
// ets_datapath
// Reciprocal-multiply quotients for days and time of day, year and month
// walkers, and the result register.
// ----------------------------------------------------------------------------
module ets_datapath (
  input  logic           clk,
  input  ets_pkg::cmd_t  cmd,
  input  logic [31:0]    seconds_since_epoch,
  output ets_pkg::stat_t stat,
  output logic [11:0]    year,
  output logic [3:0]     month,
  output logic [4:0]     day_of_month,
  output logic [4:0]     hour,
  output logic [5:0]     minute,
  output logic [5:0]     second
);

  // operand and running remainder
  logic [31:0] num;
  logic [16:0] rem;

  // working calendar state
  logic [15:0] days;
  logic [4:0]  hour_w;
  logic [5:0]  min_w;
  logic [5:0]  sec_w;
  logic [11:0] yr;
  logic [6:0]  yr_mod100;
  logic [8:0]  yr_mod400;
  logic [3:0]  mo;

  logic [24:0] recip_arg;
  logic [25:0] recip_mul;
  logic [50:0] recip_prod;
  logic [15:0] quot;
  logic [31:0] day_secs;
  logic [31:0] sod_full;
  logic [16:0] hour_secs;
  logic [16:0] min_secs;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  // shift out the power-of-two part of the divisor, then multiply by the
  // rounded-up reciprocal of the rest; exact over each operand range
  always_comb begin
    case (cmd.dsel)
      ets_pkg::DIV_DAY: begin
        recip_arg = num[31:7];
        recip_mul = ets_pkg::RECIP_DAY;
      end
      ets_pkg::DIV_HOUR: begin
        recip_arg = {12'd0, rem[16:4]};
        recip_mul = ets_pkg::RECIP_HOUR;
      end
      ets_pkg::DIV_MIN: begin
        recip_arg = {15'd0, rem[11:2]};
        recip_mul = ets_pkg::RECIP_MIN;
      end
      default: begin
        recip_arg = num[31:7];
        recip_mul = ets_pkg::RECIP_DAY;
      end
    endcase
  end

  assign recip_prod = {26'd0, recip_arg} * {25'd0, recip_mul};

  always_comb begin
    case (cmd.dsel)
      ets_pkg::DIV_HOUR: quot = {11'd0, recip_prod[25:21]};
      ets_pkg::DIV_MIN:  quot = {10'd0, recip_prod[19:14]};
      default:           quot = recip_prod[50:35];
    endcase
  end

  assign day_secs  = {16'd0, days} * {15'd0, ets_pkg::SECS_PER_DAY};
  assign sod_full  = num - day_secs;
  assign hour_secs = {12'd0, hour_w} * ets_pkg::SECS_PER_HOUR;
  assign min_secs  = {11'd0, min_w} * ets_pkg::SECS_PER_MIN;

  // Gregorian rule: every fourth year, but not centuries unless divisible by 400
  assign leap = (yr[1:0] == 2'd0) && ((yr_mod100 != 7'd0) || (yr_mod400 == 9'd0));
  assign ylen = leap ? ets_pkg::DAYS_LEAP : ets_pkg::DAYS_COMMON;
  assign mlen = ets_pkg::month_len(mo, leap);

  assign stat.year_done  = (days < {7'd0, ylen});
  assign stat.month_done = (mo == ets_pkg::MONTH_DEC) || (days < {11'd0, mlen});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num <= seconds_since_epoch;
    end else if (cmd.div_step) begin
      case (cmd.dsel)
        ets_pkg::DIV_DAY:  days   <= quot;
        ets_pkg::DIV_HOUR: hour_w <= quot[4:0];
        ets_pkg::DIV_MIN:  min_w  <= quot[5:0];
        default:           days   <= quot;
      endcase
    end else if (cmd.hour_init) begin
      // seconds of day
      rem <= sod_full[16:0];
    end else if (cmd.min_init) begin
      rem <= rem - hour_secs;
    end else if (cmd.tod_done) begin
      sec_w     <= rem[5:0] - min_secs[5:0];
      yr        <= ets_pkg::EPOCH_YEAR;
      yr_mod100 <= ets_pkg::EPOCH_MOD100;
      yr_mod400 <= ets_pkg::EPOCH_MOD400;
      mo        <= ets_pkg::MONTH_JAN;
    end else if (cmd.year_step && !stat.year_done) begin
      days      <= days - {7'd0, ylen};
      yr        <= yr + 12'd1;
      yr_mod100 <= (yr_mod100 == ets_pkg::LAST_MOD100) ? 7'd0 : yr_mod100 + 7'd1;
      yr_mod400 <= (yr_mod400 == ets_pkg::LAST_MOD400) ? 9'd0 : yr_mod400 + 9'd1;
    end else if (cmd.month_step && !stat.month_done) begin
      days <= days - {11'd0, mlen};
      mo   <= mo + 4'd1;
    end
  end

  // result register, holds while the output waits
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      year         <= yr;
      month        <= mo;
      day_of_month <= days[4:0] + 5'd1;
      hour         <= hour_w;
      minute       <= min_w;
      second       <= sec_w;
    end
  end

endmodule

// ----- rtl/ets_ctrl.sv -----
// ----------------------------------------------------------------------------
// ets_ctrl
// Sequencer for the converter: runs the quotient and remainder steps, the
// year and month walks, and owns the handshake on both channels.
// ----------------------------------------------------------------------------
module ets_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           out_ready,
  input  ets_pkg::stat_t stat,
  output logic           in_ready,
  output logic           out_valid,
  output ets_pkg::cmd_t  cmd
);

  ets_pkg::state_t state, state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ets_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.dsel       = ets_pkg::DIV_DAY;
    out_valid_next = out_valid && !out_ready;

    case (state)
      ets_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ets_pkg::S_DAY;
        end
      end
      ets_pkg::S_DAY: begin
        cmd.div_step = 1'b1;
        cmd.dsel     = ets_pkg::DIV_DAY;
        state_next   = ets_pkg::S_HOUR_INIT;
      end
      ets_pkg::S_HOUR_INIT: begin
        cmd.hour_init = 1'b1;
        state_next    = ets_pkg::S_HOUR;
      end
      ets_pkg::S_HOUR: begin
        cmd.div_step = 1'b1;
        cmd.dsel     = ets_pkg::DIV_HOUR;
        state_next   = ets_pkg::S_MIN_INIT;
      end
      ets_pkg::S_MIN_INIT: begin
        cmd.min_init = 1'b1;
        state_next   = ets_pkg::S_MIN;
      end
      ets_pkg::S_MIN: begin
        cmd.div_step = 1'b1;
        cmd.dsel     = ets_pkg::DIV_MIN;
        state_next   = ets_pkg::S_TOD_DONE;
      end
      ets_pkg::S_TOD_DONE: begin
        cmd.tod_done = 1'b1;
        state_next   = ets_pkg::S_YEAR;
      end
      ets_pkg::S_YEAR: begin
        if (stat.year_done) state_next    = ets_pkg::S_MONTH;
        else                cmd.year_step = 1'b1;
      end
      ets_pkg::S_MONTH: begin
        if (stat.month_done) state_next     = ets_pkg::S_FINISH;
        else                 cmd.month_step = 1'b1;
      end
      ets_pkg::S_FINISH: begin
        // hold until the result register is free
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ets_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ets_pkg::S_IDLE;
      end
    endcase
  end

  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ets_pkg::S_DAY))
    else $error("accepted transfer did not start the day quotient");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ets_pkg::S_FINISH)
    else $error("result raised outside the finish step");

  a_year_to_month: assert property (@(posedge clk) disable iff (rst)
    (state == ets_pkg::S_YEAR && stat.year_done) |=> state == ets_pkg::S_MONTH)
    else $error("year walk did not hand over to month walk");

  a_no_input_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ets_pkg::S_YEAR || state == ets_pkg::S_MONTH) |=> !(in_valid && in_ready)
      || state == ets_pkg::S_IDLE)
    else $error("transfer accepted during a calendar walk");

endmodule

// ----- dv/epoch_seconds_to_calendar_test.sv -----
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_test
// Drives epoch second counts into the converter and checks every returned
// calendar field against a predictor that walks years and months itself.
// Edge dates come first, then random times weighted toward year and day
// boundaries, with bursty input traffic and a stalling receiver.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_test;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned SECS_DAY     = 86400;
  localparam int unsigned BASE_YEAR    = 1970;
  localparam int unsigned LAST_YEAR    = 2106;
  localparam int unsigned RANDOM_A     = 500;
  localparam int unsigned RANDOM_B     = 525;
  localparam int unsigned LONG_HOLD    = 600;
  localparam int unsigned HOLD_AFTER   = 250;
  localparam int unsigned TAIL_CYCLES  = 250;
  localparam int unsigned PRINT_CAP    = 40;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE,
    READY_MOSTLY
  } ready_mode_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  // Days per month, index 0 unused; February patched for leap years.
  localparam int unsigned MONTH_DAYS [0:12] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30,
                                                31, 30, 31};

  logic clk;
  logic rst;

  ets_in_if  in_ch ();
  ets_out_if out_ch ();

  epoch_seconds_to_calendar dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [31:0]  pending_seconds [$];
  calendar_t    calendar_due [$];
  longint       year_start [BASE_YEAR:LAST_YEAR+1];

  int unsigned  cycles;
  int unsigned  errors;
  int unsigned  items_queued;
  int unsigned  items_in;
  int unsigned  results_done;
  int unsigned  min_year;
  int unsigned  max_year;
  bit           in_fire;

  int unsigned  burst_left;
  int unsigned  gap_left;

  ready_mode_t  ready_mode;
  int unsigned  mode_left;
  int unsigned  hold_left;
  bit           held_once;
  bit           ready_next;

  calendar_t    want;
  calendar_t    got;

  function automatic bit is_leap(input int unsigned yr);
    return ((yr % 4) == 0 && (yr % 100) != 0) || ((yr % 400) == 0);
  endfunction

  function automatic calendar_t calendar_of(input logic [31:0] secs);
    calendar_t   cal;
    int unsigned days;
    int unsigned sod;
    int unsigned yr;
    int unsigned mo;
    int unsigned len;
    bit          lp;
    days = secs / SECS_DAY;
    sod  = secs % SECS_DAY;
    yr   = BASE_YEAR;
    mo   = 1;
    // walk whole years, then whole months; December never needs stepping past
    forever begin
      len = is_leap(yr) ? 366 : 365;
      if (days < len) break;
      days -= len;
      yr++;
    end
    lp = is_leap(yr);
    while (mo < 12) begin
      len = (mo == 2 && lp) ? 29 : MONTH_DAYS[mo];
      if (days < len) break;
      days -= len;
      mo++;
    end
    cal.year   = 12'(yr);
    cal.month  = 4'(mo);
    cal.day    = 5'(days + 1);
    cal.hour   = 5'(sod / 3600);
    cal.minute = 6'((sod % 3600) / 60);
    cal.second = 6'(sod % 60);
    return cal;
  endfunction

  function automatic logic [31:0] pick_seconds();
    longint      v;
    int unsigned y;
    int unsigned sod;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5: begin
        // straddle a new year by up to three days either way
        y = $urandom_range(BASE_YEAR + 1, LAST_YEAR);
        v = year_start[y] + longint'($urandom_range(0, 6 * SECS_DAY)) - 3 * SECS_DAY;
      end
      6, 7: begin
        y = $urandom_range(BASE_YEAR, LAST_YEAR);
        case ($urandom_range(0, 2))
          0:       sod = 0;
          1:       sod = SECS_DAY - 1;
          default: sod = $urandom_range(0, SECS_DAY - 1);
        endcase
        v = year_start[y] + longint'($urandom_range(0, 365)) * SECS_DAY + sod;
      end
      8:       v = $urandom_range(0, 94694400);
      default: v = $urandom_range(32'hF000_0000, 32'hFFFF_FFFF);
    endcase
    if (v < 0) v = 0;
    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    return v[31:0];
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_CAP) $display("ERROR @%0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic wait_drained();
    while (results_done != items_queued) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic queue_item(input logic [31:0] secs);
    pending_seconds.push_back(secs);
    items_queued++;
  endtask

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               items_queued - results_done);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Driver: bursts of transfers separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_seconds.size() > 0) begin
        in_ch.valid               <= 1'b1;
        in_ch.seconds_since_epoch <= pending_seconds.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern switches to a randomly chosen mode; one long hold.
  always @(negedge clk) begin
    if (rst) begin
      ready_next = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else if (!held_once && results_done >= HOLD_AFTER) begin
      held_once  = 1'b1;
      hold_left  = LONG_HOLD;
      ready_next = 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(8, 80);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        READY_ALWAYS: ready_next = 1'b1;
        READY_HALF:   ready_next = $urandom_range(0, 1);
        READY_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
        default:      ready_next = ($urandom_range(0, 7) != 0);
      endcase
    end
    out_ch.ready <= ready_next;
  end

  // Monitor: predict on input transfers, compare on output transfers.
  always @(posedge clk) begin
    if (rst) begin
      in_fire = 1'b0;
    end else begin
      in_fire = in_ch.valid && in_ch.ready;
      if (in_fire) begin
        calendar_due.push_back(calendar_of(in_ch.seconds_since_epoch));
        items_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.year, out_ch.month, out_ch.day_of_month, out_ch.hour,
                out_ch.minute, out_ch.second};
        if (calendar_due.size() == 0) begin
          report_mismatch($sformatf("result %0d-%0d-%0d with no conversion pending",
                                    got.year, got.month, got.day));
        end else begin
          want = calendar_due.pop_front();
          if (got.year != want.year)
            report_mismatch($sformatf("year got %0d want %0d", got.year, want.year));
          if (got.month != want.month)
            report_mismatch($sformatf("month got %0d want %0d", got.month, want.month));
          if (got.day != want.day)
            report_mismatch($sformatf("day_of_month got %0d want %0d", got.day, want.day));
          if (got.hour != want.hour)
            report_mismatch($sformatf("hour got %0d want %0d", got.hour, want.hour));
          if (got.minute != want.minute)
            report_mismatch($sformatf("minute got %0d want %0d", got.minute, want.minute));
          if (got.second != want.second)
            report_mismatch($sformatf("second got %0d want %0d", got.second, want.second));
          if (want.year < min_year) min_year = want.year;
          if (want.year > max_year) max_year = want.year;
        end
        results_done++;
      end
    end
  end

  initial begin
    rst                       = 1'b1;
    in_ch.valid               = 1'b0;
    in_ch.seconds_since_epoch = '0;
    out_ch.ready              = 1'b0;
    cycles       = 0;
    errors       = 0;
    items_queued = 0;
    items_in     = 0;
    results_done = 0;
    min_year     = LAST_YEAR;
    max_year     = BASE_YEAR;
    in_fire      = 1'b0;
    burst_left   = 0;
    gap_left     = 0;
    ready_mode   = READY_ALWAYS;
    mode_left    = 0;
    hold_left    = 0;
    held_once    = 1'b0;
    ready_next   = 1'b0;

    year_start[BASE_YEAR] = 0;
    for (int unsigned y = BASE_YEAR; y <= LAST_YEAR; y++)
      year_start[y+1] = year_start[y] + (is_leap(y) ? 366 : 365) * longint'(SECS_DAY);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // edge dates: field rollovers, leap days, century rule, range ends
    queue_item(32'd0);
    queue_item(32'd59);
    queue_item(32'd60);
    queue_item(32'd3599);
    queue_item(32'd3600);
    queue_item(32'd86399);
    queue_item(32'd86400);
    queue_item(32'd31535999);
    queue_item(32'd31536000);
    queue_item(32'd68169599);
    queue_item(32'd68169600);
    queue_item(32'd68255999);
    queue_item(32'd68256000);
    queue_item(32'd951782400);
    queue_item(32'd951868800);
    queue_item(32'd978307199);
    queue_item(32'd978307200);
    queue_item(32'd4107542399);
    queue_item(32'd4107542400);
    queue_item(32'd4291747199);
    queue_item(32'd4291747200);
    queue_item(32'h7FFF_FFFF);
    queue_item(32'h8000_0000);
    queue_item(32'hAAAA_AAAA);
    queue_item(32'h5555_5555);
    queue_item(32'hFFFF_FFFF);
    wait_drained();

    for (int unsigned i = 0; i < RANDOM_A; i++) queue_item(pick_seconds());
    wait_drained();

    for (int unsigned i = 0; i < RANDOM_B; i++) queue_item(pick_seconds());
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    while (calendar_due.size() > 0) begin
      want = calendar_due.pop_front();
      report_mismatch($sformatf("no result for expected %0d-%0d-%0d",
                                want.year, want.month, want.day));
    end

    $display("Checked %0d conversions of %0d transfers in, years %0d..%0d, %0d cycles",
             results_done, items_in, min_year, max_year, cycles);
    $display("Included bursty input, mixed output stalls and a %0d-cycle output hold",
             LONG_HOLD);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ets_pkg.sv
rtl/ets_if.sv
rtl/ets_datapath.sv
rtl/ets_ctrl.sv
rtl/epoch_seconds_to_calendar.sv
dv/epoch_seconds_to_calendar_test.sv
